FILE: rtl/cstr_pkg.sv
package cstr_pkg;

    // Request command codes
    typedef enum logic [2:0] {
        CMD_JOIN      = 3'd0,
        CMD_LIST      = 3'd1,
        CMD_BROADCAST = 3'd2,
        CMD_DIRECT    = 3'd3,
        CMD_LEAVE     = 3'd4,
        CMD_SHUTDOWN  = 3'd5
    } cmd_e_t;

    // Result kinds
    typedef enum logic [2:0] {
        KIND_GRANT   = 3'd0,
        KIND_LIST    = 3'd1,
        KIND_FORWARD = 3'd2,
        KIND_STOP    = 3'd3,
        KIND_FULL    = 3'd4
    } kind_e_t;

    localparam int ID_W    = 4;
    localparam int QUEUE_W = 31;
    localparam int BODY_W  = 32;
    localparam int CNT_W   = 5;

    // At most this many results per request
    localparam logic [CNT_W-1:0] RES_CAP  = 5'd16;
    localparam logic [CNT_W-1:0] RES_LAST = 5'd15;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [ID_W-1:0]    sender_slot;
        logic [ID_W-1:0]    target_slot;
        logic [QUEUE_W-1:0] reply_queue;
        logic [BODY_W-1:0]  body_handle;
    } req_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [QUEUE_W-1:0] dest_queue;
        logic [ID_W-1:0]    slot_number;
        logic [BODY_W-1:0]  body_out;
        logic               last_of_run;
    } res_t;

    // Classified request as held in the command queue
    typedef struct packed {
        cmd_e_t             op;
        logic [ID_W-1:0]    sender_slot;
        logic [ID_W-1:0]    target_slot;
        logic [QUEUE_W-1:0] reply_queue;
        logic [BODY_W-1:0]  body_handle;
    } cmd_t;

    // Queue status seen by the engine
    typedef struct packed {
        logic valid;
        cmd_t head;
    } qhead_t;

endpackage

FILE: rtl/cstr_front.sv
module cstr_front #(
    parameter int SLOTS = 16
) (
    input  logic           s_valid,
    output logic           s_ready,
    input  cstr_pkg::req_t s_req,
    input  logic           q_full,
    output logic           q_push,
    output cstr_pkg::cmd_t q_cmd
);

    localparam logic [6:0] LIM = 7'(SLOTS);

    logic snd_ok;
    logic tgt_ok;
    logic keep;

    assign snd_ok = 7'(s_req.sender_slot) < LIM;
    assign tgt_ok = 7'(s_req.target_slot) < LIM;

    // Drop requests that can have no effect: unknown codes, bad ids
    always_comb begin
        case (s_req.cmd)
            cstr_pkg::CMD_JOIN:      keep = 1'b1;
            cstr_pkg::CMD_LIST:      keep = snd_ok;
            cstr_pkg::CMD_BROADCAST: keep = snd_ok;
            cstr_pkg::CMD_DIRECT:    keep = snd_ok && tgt_ok;
            cstr_pkg::CMD_LEAVE:     keep = snd_ok;
            cstr_pkg::CMD_SHUTDOWN:  keep = 1'b1;
            default:                 keep = 1'b0;
        endcase
    end

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

    assign q_cmd.op          = cstr_pkg::cmd_e_t'(s_req.cmd);
    assign q_cmd.sender_slot = s_req.sender_slot;
    assign q_cmd.target_slot = s_req.target_slot;
    assign q_cmd.reply_queue = s_req.reply_queue;
    assign q_cmd.body_handle = s_req.body_handle;

endmodule

FILE: rtl/cstr_cmd_queue.sv
module cstr_cmd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  cstr_pkg::cmd_t   push_cmd,
    output logic             full,
    input  logic             pop,
    output cstr_pkg::qhead_t head
);

    // Two-entry queue
    cstr_pkg::cmd_t ent_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     count_reg, count_next;

    assign full       = count_reg == 2'd2;
    assign head.valid = count_reg != 2'd0;
    assign head.head  = ent_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

FILE: rtl/cstr_engine.sv
module cstr_engine #(
    parameter int SLOTS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cstr_pkg::qhead_t q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output cstr_pkg::res_t   m_res
);

    localparam int SW = $clog2(SLOTS);
    localparam int NW = $clog2(SLOTS + 1);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_LQ     = 6'b000010,
        ST_WALK   = 6'b000100,
        ST_DRAIN  = 6'b001000,
        ST_DOUT   = 6'b010000,
        ST_SEARCH = 6'b100000
    } state_t;

    state_t                          state_reg, state_next;
    logic [SLOTS-1:0]                conn_reg, conn_next;
    logic [NW-1:0]                   nfs_reg, nfs_next;
    cstr_pkg::cmd_t                  cur_reg, cur_next;
    logic [SW-1:0]                   idx_reg, idx_next;
    logic [SW-1:0]                   step_reg, step_next;
    logic [SLOTS-1:0]                rem_reg, rem_next;
    logic [cstr_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [cstr_pkg::QUEUE_W-1:0]    listq_reg, listq_next;
    logic                            b_valid_reg, b_valid_next;
    logic [SW-1:0]                   b_slot_reg, b_slot_next;
    logic                            b_last_reg, b_last_next;
    logic                            out_valid_reg;
    cstr_pkg::res_t                  out_reg;

    // Reply queue store
    logic [cstr_pkg::QUEUE_W-1:0]    qmem [SLOTS];
    logic [cstr_pkg::QUEUE_W-1:0]    rdata_reg;
    logic                            rd_en;
    logic [SW-1:0]                   rd_addr;
    logic                            wr_en;

    logic                            out_free;
    logic                            out_load;
    cstr_pkg::res_t                  out_next;
    logic                            full;
    logic [SW-1:0]                   nfs_idx;
    logic [SW-1:0]                   q_snd;
    logic [SW-1:0]                   q_tgt;
    logic [SW-1:0]                   cur_snd;
    logic [SW-1:0]                   idx_wrap;
    logic [SLOTS-1:0]                idx_onehot;
    logic [SLOTS-1:0]                snd_onehot;
    logic [SLOTS-1:0]                rem_after;
    logic                            adv;

    assign out_free   = !out_valid_reg || m_ready;
    assign full       = nfs_reg == NW'(SLOTS);
    assign nfs_idx    = nfs_reg[SW-1:0];
    assign q_snd      = SW'(q_head.head.sender_slot);
    assign q_tgt      = SW'(q_head.head.target_slot);
    assign cur_snd    = SW'(cur_reg.sender_slot);
    assign idx_wrap   = (idx_reg == SW'(SLOTS - 1)) ? '0 : idx_reg + 1'b1;
    assign idx_onehot = {{(SLOTS-1){1'b0}}, 1'b1} << idx_reg;
    assign snd_onehot = {{(SLOTS-1){1'b0}}, 1'b1} << q_snd;
    assign rem_after  = rem_reg & ~idx_onehot;
    assign adv        = !b_valid_reg || out_free;

    always_comb begin
        state_next   = state_reg;
        conn_next    = conn_reg;
        nfs_next     = nfs_reg;
        cur_next     = cur_reg;
        idx_next     = idx_reg;
        step_next    = step_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        listq_next   = listq_reg;
        b_valid_next = b_valid_reg;
        b_slot_next  = b_slot_reg;
        b_last_next  = b_last_reg;
        q_pop        = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = idx_reg;
        wr_en        = 1'b0;
        out_load     = 1'b0;
        out_next     = '0;

        // Walk output stage drains into the result register
        if (b_valid_reg && out_free) begin
            out_load             = 1'b1;
            out_next.last_of_run = b_last_reg;
            b_valid_next         = 1'b0;
            case (cur_reg.op)
                cstr_pkg::CMD_LIST: begin
                    out_next.kind        = cstr_pkg::KIND_LIST;
                    out_next.dest_queue  = listq_reg;
                    out_next.slot_number = cstr_pkg::ID_W'(b_slot_reg);
                end
                cstr_pkg::CMD_BROADCAST: begin
                    out_next.kind        = cstr_pkg::KIND_FORWARD;
                    out_next.dest_queue  = rdata_reg;
                    out_next.slot_number = cur_reg.sender_slot;
                    out_next.body_out    = cur_reg.body_handle;
                end
                default: begin
                    out_next.kind        = cstr_pkg::KIND_STOP;
                    out_next.dest_queue  = rdata_reg;
                end
            endcase
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_head.valid && out_free) begin
                    q_pop    = 1'b1;
                    cur_next = q_head.head;
                    idx_next = '0;
                    cnt_next = '0;
                    unique case (q_head.head.op)
                        cstr_pkg::CMD_JOIN: begin
                            out_load             = 1'b1;
                            out_next.dest_queue  = q_head.head.reply_queue;
                            out_next.last_of_run = 1'b1;
                            if (full) begin
                                out_next.kind = cstr_pkg::KIND_FULL;
                            end else begin
                                out_next.kind        = cstr_pkg::KIND_GRANT;
                                out_next.slot_number = cstr_pkg::ID_W'(nfs_idx);
                                conn_next[nfs_idx]   = 1'b1;
                                wr_en                = 1'b1;
                                idx_next             = nfs_idx;
                                step_next            = '0;
                                state_next           = ST_SEARCH;
                            end
                        end
                        cstr_pkg::CMD_LIST: begin
                            rd_en      = 1'b1;
                            rd_addr    = q_snd;
                            rem_next   = conn_reg;
                            state_next = ST_LQ;
                        end
                        cstr_pkg::CMD_BROADCAST: begin
                            rem_next   = conn_reg & ~snd_onehot;
                            state_next = ST_WALK;
                        end
                        cstr_pkg::CMD_DIRECT: begin
                            if (conn_reg[q_tgt]) begin
                                rd_en      = 1'b1;
                                rd_addr    = q_tgt;
                                state_next = ST_DOUT;
                            end
                        end
                        cstr_pkg::CMD_LEAVE: begin
                            conn_next[q_snd] = 1'b0;
                            if (full) begin
                                nfs_next = NW'(q_snd);
                            end
                        end
                        cstr_pkg::CMD_SHUTDOWN: begin
                            rem_next   = conn_reg;
                            state_next = ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LQ: begin
                listq_next = conn_reg[cur_snd] ? rdata_reg : '0;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (adv) begin
                    rem_next = rem_after;
                    if (rem_reg[idx_reg] && (cnt_reg < cstr_pkg::RES_CAP)) begin
                        rd_en        = 1'b1;
                        b_valid_next = 1'b1;
                        b_slot_next  = idx_reg;
                        b_last_next  = (rem_after == '0) || (cnt_reg == cstr_pkg::RES_LAST);
                        cnt_next     = cnt_reg + 1'b1;
                    end
                    if (idx_reg == SW'(SLOTS - 1)) begin
                        state_next = ST_DRAIN;
                        if (cur_reg.op == cstr_pkg::CMD_SHUTDOWN) begin
                            conn_next = '0;
                            nfs_next  = '0;
                        end
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!b_valid_reg) begin
                    state_next = ST_IDLE;
                end
            end
            ST_DOUT: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    out_next.kind        = cstr_pkg::KIND_FORWARD;
                    out_next.dest_queue  = rdata_reg;
                    out_next.slot_number = cur_reg.sender_slot;
                    out_next.body_out    = cur_reg.body_handle;
                    out_next.last_of_run = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            ST_SEARCH: begin
                // Round-robin scan for the next unconnected slot
                idx_next = idx_wrap;
                if (!conn_reg[idx_wrap]) begin
                    nfs_next   = NW'(idx_wrap);
                    state_next = ST_IDLE;
                end else if (step_reg == SW'(SLOTS - 2)) begin
                    nfs_next   = NW'(SLOTS);
                    state_next = ST_IDLE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            conn_reg      <= '0;
            nfs_reg       <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            conn_reg    <= conn_next;
            nfs_reg     <= nfs_next;
            b_valid_reg <= b_valid_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        idx_reg    <= idx_next;
        step_reg   <= step_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        listq_reg  <= listq_next;
        b_slot_reg <= b_slot_next;
        b_last_reg <= b_last_next;
        if (out_load) begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            qmem[nfs_idx] <= q_head.head.reply_queue;
        end
        if (rd_en) begin
            rdata_reg <= qmem[rd_addr];
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

endmodule

FILE: rtl/client_slot_table_router.sv
// Client slot table router.
// Input channel s_valid/s_ready/s_req carries one request (join, list,
// broadcast, direct, leave, shutdown). Result channel m_valid/m_ready/m_res
// carries zero to 16 results per request, in order; last_of_run marks the
// final result of a request. A request with no result sends nothing.
// The front classifies each request, drops unknown codes and out-of-range
// slot ids, and parks the rest in a two-entry queue, so s_ready stays high
// until the queue is full. The engine walks the slot table one slot a cycle
// while the result path does not stall, through the connected bits and the
// single read port of the queue store, one request at a time:
//   join: sends its result, then on a grant searches for the next free slot
//   list: reads the sender's reply queue, then walks the connected slots
//   broadcast, shutdown: walk the connected slots
//   direct: reads the target's reply queue; leave: clears the sender's mark
// A result sits in an output register; while m_ready is low the engine
// freezes mid-walk and the queue fills, after which s_ready drops.
// Reset (aresetn low, synchronous) empties the queue, clears every
// connected mark and points the next free slot at slot 0.
module client_slot_table_router #(
    parameter int SLOTS = 16
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  cstr_pkg::req_t s_req,
    output logic           m_valid,
    input  logic           m_ready,
    output cstr_pkg::res_t m_res
);

    logic             q_full;
    logic             q_push;
    logic             q_pop;
    cstr_pkg::cmd_t   q_cmd;
    cstr_pkg::qhead_t q_head;

    // Request classification and filtering
    cstr_front #(
        .SLOTS (SLOTS)
    ) u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_req   (s_req),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_cmd   (q_cmd)
    );

    // Decouples the front from the table walk
    cstr_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    // Slot table, reply queue store and result generation
    cstr_engine #(
        .SLOTS (SLOTS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_res   (m_res)
    );

endmodule

FILE: rtl/cstr_checker.sv
module cstr_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input cstr_pkg::req_t s_req,
    input logic           m_valid,
    input logic           m_ready,
    input cstr_pkg::res_t m_res
);

    // Stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_res))
        else $error("result changed while stalled");

    // Grants and table-full errors are always single results
    a_single: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_res.kind == cstr_pkg::KIND_GRANT || m_res.kind == cstr_pkg::KIND_FULL)
        |-> m_res.last_of_run)
        else $error("grant or full error not marked last");

    // Only forwards carry a body
    a_body: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.kind != cstr_pkg::KIND_FORWARD |-> m_res.body_out == '0)
        else $error("body on a non-forward result");

    // Stop notices and full errors carry slot zero
    a_slot0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_res.kind == cstr_pkg::KIND_STOP || m_res.kind == cstr_pkg::KIND_FULL)
        |-> m_res.slot_number == '0)
        else $error("nonzero slot on stop or full error");

    // Nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind client_slot_table_router cstr_checker u_cstr_checker (.*);
